### rtl/stuffed_frame_receiver_unit_macros.svh
// ----------------------------------------------------------------------------
// Stuffed frame receiver assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Types and codes shared by the deframer modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_FLAG    = 3'd1;
  localparam logic [2:0] PH_ADDR    = 3'd2;
  localparam logic [2:0] PH_CTRL    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_ESCAPE  = 3'd5;

  localparam logic [2:0] EV_PAYLOAD   = 3'd0;
  localparam logic [2:0] EV_GOOD_NEW  = 3'd1;
  localparam logic [2:0] EV_GOOD_DUP  = 3'd2;
  localparam logic [2:0] EV_BAD_CHECK = 3'd3;
  localparam logic [2:0] EV_BAD_ESC   = 3'd4;

  localparam logic [2:0] REG_FLAG     = 3'd0;
  localparam logic [2:0] REG_ADDRESS  = 3'd1;
  localparam logic [2:0] REG_ESCAPE   = 3'd2;
  localparam logic [2:0] REG_ESC_FLAG = 3'd3;
  localparam logic [2:0] REG_ESC_ESC  = 3'd4;
  localparam logic [2:0] REG_CTRL0    = 3'd5;
  localparam logic [2:0] REG_CTRL1    = 3'd6;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] address_value;
    logic [7:0] escape_value;
    logic [7:0] escaped_flag_code;
    logic [7:0] escaped_escape_code;
    logic [7:0] control_seq0;
    logic [7:0] control_seq1;
  } cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       current_seq;
    logic [7:0] control_seen;
    logic [7:0] held_byte;
    logic       held_valid;
    logic [7:0] running_xor;
    logic       expected_seq;
    logic       emitted_any;
  } state_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] payload_byte;
    logic       frame_sequence;
    logic       reply_sequence;
  } result_t;

endpackage

### rtl/stuffed_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver unit
// Byte-stuffed frame deframer with header check, payload XOR check and
// sequence tracking.
//
//   Channel  Direction  Contents
//   s_axis   in         tdata[7:0] rx_byte
//   m_axis   out        tuser event_kind; tdata payload, sequences
//   cfg      in         write enable, register index, 8-bit data
//
// One byte is accepted per cycle while s_axis_tready is high; its state update
// is a single registered step. An output register plus one skid entry hold
// results, a result going to the skid entry only while the output is stalled;
// s_axis_tready falls only when both are occupied by a stalled output.
// Reset clears the frame state and loads the default register values.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] frame_sequence,
                                      // [9] reply_sequence, [15:10] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import sfr_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value          <= 8'd126;
      cfg.address_value       <= 8'd3;
      cfg.escape_value        <= 8'd125;
      cfg.escaped_flag_code   <= 8'd94;
      cfg.escaped_escape_code <= 8'd93;
      cfg.control_seq0        <= 8'd0;
      cfg.control_seq1        <= 8'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLAG:     cfg.flag_value          <= cfg_data;
        REG_ADDRESS:  cfg.address_value       <= cfg_data;
        REG_ESCAPE:   cfg.escape_value        <= cfg_data;
        REG_ESC_FLAG: cfg.escaped_flag_code   <= cfg_data;
        REG_ESC_ESC:  cfg.escaped_escape_code <= cfg_data;
        REG_CTRL0:    cfg.control_seq0        <= cfg_data;
        REG_CTRL1:    cfg.control_seq1        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfr_step u_step (
    .cfg        (cfg),
    .state      (state),
    .rx_byte    (s_axis_tdata),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  sfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && res_valid),
    .in_data   (res),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tuser = out_res.event_kind;
  assign m_axis_tdata = {6'd0, out_res.reply_sequence, out_res.frame_sequence,
                         out_res.payload_byte};

endmodule

### rtl/sfr_step.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver step logic
// Next state and optional result for one received byte.
// ----------------------------------------------------------------------------
module sfr_step (
  input  sfr_pkg::cfg_t    cfg,
  input  sfr_pkg::state_t  state,
  input  logic [7:0]       rx_byte,
  output sfr_pkg::state_t  state_next,
  output logic             res_valid,
  output sfr_pkg::result_t res
);
  import sfr_pkg::*;

  logic       take;
  logic [7:0] data_byte;
  logic       good;

  assign good = (state.running_xor == 8'd0) && state.emitted_any;

  always_comb begin
    state_next         = state;
    res_valid          = 1'b0;
    res.event_kind     = EV_PAYLOAD;
    res.payload_byte   = 8'd0;
    res.frame_sequence = state.current_seq;
    res.reply_sequence = ~state.current_seq;
    take               = 1'b0;
    data_byte          = rx_byte;
    case (state.phase)
      PH_FLAG: begin
        if (rx_byte == cfg.address_value) begin
          state_next.phase = PH_ADDR;
        end else if (rx_byte == cfg.flag_value) begin
          state_next.phase = PH_FLAG;
        end else begin
          state_next.phase = PH_HUNT;
        end
      end
      PH_ADDR: begin
        if (rx_byte == cfg.control_seq0 || rx_byte == cfg.control_seq1) begin
          state_next.current_seq  = (rx_byte != cfg.control_seq0);
          state_next.control_seen = rx_byte;
          state_next.phase        = PH_CTRL;
        end else if (rx_byte == cfg.flag_value) begin
          state_next.phase = PH_FLAG;
        end else begin
          state_next.phase = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (rx_byte == (cfg.address_value ^ state.control_seen)) begin
          state_next.phase       = PH_PAYLOAD;
          state_next.held_byte   = 8'd0;
          state_next.held_valid  = 1'b0;
          state_next.running_xor = 8'd0;
          state_next.emitted_any = 1'b0;
        end else begin
          state_next.phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == cfg.flag_value) begin
          res_valid        = 1'b1;
          state_next.phase = PH_HUNT;
          if (good && (state.current_seq == state.expected_seq)) begin
            res.event_kind          = EV_GOOD_NEW;
            state_next.expected_seq = ~state.expected_seq;
          end else if (good) begin
            res.event_kind = EV_GOOD_DUP;
          end else begin
            res.event_kind = EV_BAD_CHECK;
          end
        end else if (rx_byte == cfg.escape_value) begin
          state_next.phase = PH_ESCAPE;
        end else begin
          take = 1'b1;
        end
      end
      PH_ESCAPE: begin
        if (rx_byte == cfg.escaped_flag_code) begin
          state_next.phase = PH_PAYLOAD;
          take             = 1'b1;
          data_byte        = cfg.flag_value;
        end else if (rx_byte == cfg.escaped_escape_code) begin
          state_next.phase = PH_PAYLOAD;
          take             = 1'b1;
          data_byte        = cfg.escape_value;
        end else begin
          res_valid        = 1'b1;
          res.event_kind   = EV_BAD_ESC;
          state_next.phase = PH_HUNT;
        end
      end
      default: begin
        state_next.phase = (rx_byte == cfg.flag_value) ? PH_FLAG : PH_HUNT;
      end
    endcase
    if (take) begin
      if (state.held_valid) begin
        res_valid              = 1'b1;
        res.event_kind         = EV_PAYLOAD;
        res.payload_byte       = state.held_byte;
        state_next.emitted_any = 1'b1;
      end
      state_next.held_byte   = data_byte;
      state_next.held_valid  = 1'b1;
      state_next.running_xor = state.running_xor ^ data_byte;
    end
  end

endmodule

### rtl/sfr_skid.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver output buffer
// Output register with a skid stage; input is refused only while the skid is full.
// ----------------------------------------------------------------------------
module sfr_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sfr_pkg::result_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  output sfr_pkg::result_t out_data,
  input  logic             out_ready
);
  import sfr_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_valid && in_ready) begin
        skid_valid <= 1'b1;
        skid_data  <= in_data;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      out_data  <= in_data;
    end
  end

endmodule

### rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "stuffed_frame_receiver_unit_macros.svh"

module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import sfr_pkg::*;

  `SFR_ASSERT_NOW(a_kind_range, m_axis_tvalid, m_axis_tuser <= EV_BAD_ESC)
  `SFR_ASSERT_NOW(a_reply_inverse, m_axis_tvalid, m_axis_tdata[9] != m_axis_tdata[8])
  `SFR_ASSERT_NOW(a_no_data_on_event, m_axis_tvalid && (m_axis_tuser != EV_PAYLOAD), m_axis_tdata[7:0] == 8'd0)
  `SFR_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid && !$past(m_axis_tready))
  `SFR_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind stuffed_frame_receiver_unit sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### test/stuffed_frame_receiver_unit_checker.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver checker
// Watches the byte input, the event output and the register write port of
// the deframer. Keeps its own copy of the registers and the frame state, and
// predicts the events that each accepted byte causes. Every event that leaves
// the block is compared with the oldest prediction. Hands the mismatch count
// and the number of outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          verdicts
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  cfg_t       regs;
  logic [2:0] step_phase;
  logic       frame_seq;
  logic       accept_seq;
  logic [7:0] ctrl_byte;
  logic [7:0] held_byte;
  logic       held_ok;
  logic [7:0] frame_xor;
  logic       data_out;
  result_t    event_q[$];
  int         err_count;
  int         check_count;
  int         verdict_count;

  function automatic result_t make_event(input logic [2:0] kind, input logic [7:0] data);
    result_t r;
    r.event_kind     = kind;
    r.payload_byte   = data;
    r.frame_sequence = frame_seq;
    r.reply_sequence = ~frame_seq;
    return r;
  endfunction

  task automatic absorb_byte(input logic [7:0] d);
    if (held_ok) begin
      event_q.push_back(make_event(EV_PAYLOAD, held_byte));
      data_out = 1'b1;
    end
    held_byte = d;
    held_ok   = 1'b1;
    frame_xor = frame_xor ^ d;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [2:0] kind;
    case (step_phase)
      PH_FLAG: begin
        if (b == regs.address_value) step_phase = PH_ADDR;
        else if (b == regs.flag_value) step_phase = PH_FLAG;
        else step_phase = PH_HUNT;
      end
      PH_ADDR: begin
        if (b == regs.control_seq0 || b == regs.control_seq1) begin
          frame_seq  = (b == regs.control_seq0) ? 1'b0 : 1'b1;
          ctrl_byte  = b;
          step_phase = PH_CTRL;
        end else if (b == regs.flag_value) begin
          step_phase = PH_FLAG;
        end else begin
          step_phase = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (b == (regs.address_value ^ ctrl_byte)) begin
          step_phase = PH_PAYLOAD;
          held_byte  = 8'h00;
          held_ok    = 1'b0;
          frame_xor  = 8'h00;
          data_out   = 1'b0;
        end else begin
          step_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (b == regs.flag_value) begin
          if (frame_xor == 8'h00 && data_out) begin
            if (frame_seq == accept_seq) begin
              kind       = EV_GOOD_NEW;
              accept_seq = ~accept_seq;
            end else begin
              kind = EV_GOOD_DUP;
            end
          end else begin
            kind = EV_BAD_CHECK;
          end
          event_q.push_back(make_event(kind, 8'h00));
          verdict_count++;
          step_phase = PH_HUNT;
        end else if (b == regs.escape_value) begin
          step_phase = PH_ESCAPE;
        end else begin
          absorb_byte(b);
        end
      end
      PH_ESCAPE: begin
        if (b == regs.escaped_flag_code) begin
          step_phase = PH_PAYLOAD;
          absorb_byte(regs.flag_value);
        end else if (b == regs.escaped_escape_code) begin
          step_phase = PH_PAYLOAD;
          absorb_byte(regs.escape_value);
        end else begin
          event_q.push_back(make_event(EV_BAD_ESC, 8'h00));
          step_phase = PH_HUNT;
        end
      end
      default: step_phase = (b == regs.flag_value) ? PH_FLAG : PH_HUNT;
    endcase
  endtask

  task automatic note_mismatch(input string what, input result_t want);
    err_count++;
    if (err_count <= 10)
      $display("ERROR at %0t: %s: expected kind=%0d byte=%02h seq=%0d reply=%0d, %s%0d %s%04h",
               $time, what, want.event_kind, want.payload_byte, want.frame_sequence,
               want.reply_sequence, "got kind=", m_tuser, "tdata=", m_tdata);
  endtask

  task automatic compare_event();
    result_t want;
    if (event_q.size() == 0) begin
      note_mismatch("event with nothing expected", '0);
    end else begin
      want = event_q.pop_front();
      check_count++;
      if (m_tuser !== want.event_kind || m_tdata[7:0] !== want.payload_byte ||
          m_tdata[8] !== want.frame_sequence || m_tdata[9] !== want.reply_sequence ||
          m_tdata[15:10] !== 6'd0)
        note_mismatch("event mismatch", want);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs       = '{8'd126, 8'd3, 8'd125, 8'd94, 8'd93, 8'd0, 8'd64};
      step_phase = PH_HUNT;
      frame_seq  = 1'b0;
      accept_seq = 1'b0;
      ctrl_byte  = 8'h00;
      held_byte  = 8'h00;
      held_ok    = 1'b0;
      frame_xor  = 8'h00;
      data_out   = 1'b0;
      event_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FLAG:     regs.flag_value          = cfg_data;
          REG_ADDRESS:  regs.address_value       = cfg_data;
          REG_ESCAPE:   regs.escape_value        = cfg_data;
          REG_ESC_FLAG: regs.escaped_flag_code   = cfg_data;
          REG_ESC_ESC:  regs.escaped_escape_code = cfg_data;
          REG_CTRL0:    regs.control_seq0        = cfg_data;
          REG_CTRL1:    regs.control_seq1        = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) compare_event();
      if (s_tvalid && s_tready) predict_byte(s_tdata);
      pending <= event_q.size();
    end
    errors   <= err_count;
    checked  <= check_count;
    verdicts <= verdict_count;
  end

endmodule

### test/stuffed_frame_receiver_unit_test.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver testbench
// Drives received bytes into the deframer: a short directed string under the
// reset registers, then random frames (good, duplicate, bad check, bad escape,
// empty, broken header, line noise) under several register settings, extremes
// and degenerate codes among them. Both sides stall at random, except under
// the extreme setting. A separate checker predicts and compares every event.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam cfg_t DEFAULT_CFG = '{8'd126, 8'd3, 8'd125, 8'd94, 8'd93, 8'd0, 8'd64};
  localparam cfg_t EXTREME_CFG = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
  localparam cfg_t DEGENERATE_CFG = '{8'h55, 8'hA5, 8'h55, 8'h0F, 8'h0F, 8'h11, 8'h11};

  // Flag-in-address and flag-in-control restarts, a good frame with both
  // stuffed pairs, a byte after the closing flag, a header check byte that is
  // the flag, and a bad byte after escape.
  localparam logic [7:0] OPENING [25] = '{
    8'h7E, 8'h7E, 8'h03, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h5E, 8'h7D,
    8'h5D, 8'hFF, 8'hFC, 8'h7E, 8'h03, 8'h7E, 8'h03, 8'h40, 8'h7E, 8'h7E,
    8'h03, 8'h40, 8'h43, 8'h7D, 8'h12};

  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_ESC, FR_EMPTY, FR_BAD_HDR, FR_NOISE} frame_kind_e;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'h00;
  bit          calm = 1'b0;
  int          errors;
  int          pending;
  int          checked;
  int          verdicts;
  int          items_sent = 0;
  int          settings_used = 1;
  cfg_t        line_cfg = DEFAULT_CFG;
  logic [7:0]  line_q[$];

  stuffed_frame_receiver_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stuffed_frame_receiver_unit_checker watcher (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked), .verdicts(verdicts)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 17);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_t c, input bit with_unused);
    wait_idle();
    if (with_unused) write_reg(REG_UNUSED, 8'($urandom_range(255)));
    write_reg(REG_FLAG, c.flag_value);
    write_reg(REG_ADDRESS, c.address_value);
    write_reg(REG_ESCAPE, c.escape_value);
    write_reg(REG_ESC_FLAG, c.escaped_flag_code);
    write_reg(REG_ESC_ESC, c.escaped_escape_code);
    write_reg(REG_CTRL0, c.control_seq0);
    write_reg(REG_CTRL1, c.control_seq1);
    cfg_we <= 1'b0;
    line_cfg = c;
    settings_used++;
  endtask

  function automatic void push_data(input logic [7:0] d);
    if (d == line_cfg.flag_value) begin
      line_q.push_back(line_cfg.escape_value);
      line_q.push_back(line_cfg.escaped_flag_code);
    end else if (d == line_cfg.escape_value) begin
      line_q.push_back(line_cfg.escape_value);
      line_q.push_back(line_cfg.escaped_escape_code);
    end else begin
      line_q.push_back(d);
    end
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(9))
      0: return line_cfg.flag_value;
      1: return line_cfg.escape_value;
      2: return $urandom_range(1) ? 8'h00 : 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] spoil(input logic [7:0] v);
    if ($urandom_range(1)) return line_cfg.flag_value;
    return v ^ 8'($urandom_range(255, 1));
  endfunction

  function automatic frame_kind_e pick_kind();
    int r = $urandom_range(99);
    if (r < 68) return FR_GOOD;
    if (r < 76) return FR_BAD_SUM;
    if (r < 82) return FR_BAD_ESC;
    if (r < 88) return FR_EMPTY;
    if (r < 95) return FR_BAD_HDR;
    return FR_NOISE;
  endfunction

  task automatic send_frame(input frame_kind_e kind);
    logic [7:0] ctrl;
    logic [7:0] sum;
    logic [7:0] d;
    logic [7:0] junk;
    int         len;
    int         bad_at;
    int         hdr_pos;
    ctrl = $urandom_range(1) ? line_cfg.control_seq1 : line_cfg.control_seq0;
    len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
    if (kind == FR_EMPTY) len = 0;
    bad_at = $urandom_range(len - 1);
    hdr_pos = (kind == FR_BAD_HDR) ? $urandom_range(2) : 3;
    sum = 8'h00;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(4, 1)) line_q.push_back(pick_data());
    end else begin
      line_q.push_back(line_cfg.flag_value);
      line_q.push_back(hdr_pos == 0 ? spoil(line_cfg.address_value) : line_cfg.address_value);
      line_q.push_back(hdr_pos == 1 ? spoil(ctrl) : ctrl);
      line_q.push_back(hdr_pos == 2 ? spoil(line_cfg.address_value ^ ctrl)
                                    : line_cfg.address_value ^ ctrl);
      for (int i = 0; i < len; i++) begin
        if (kind == FR_BAD_ESC && i == bad_at) begin
          do junk = 8'($urandom_range(255));
          while (junk == line_cfg.escaped_flag_code || junk == line_cfg.escaped_escape_code);
          line_q.push_back(line_cfg.escape_value);
          line_q.push_back(junk);
        end
        d = pick_data();
        sum = sum ^ d;
        push_data(d);
      end
      if (kind == FR_BAD_SUM) sum = sum ^ 8'($urandom_range(255, 1));
      if (kind != FR_EMPTY || $urandom_range(1)) push_data(sum);
      line_q.push_back(line_cfg.flag_value);
    end
    while (line_q.size() != 0) send_byte(line_q.pop_front());
  endtask

  task automatic run_frames(input int count);
    int target = items_sent + count;
    while (items_sent < target) send_frame(pick_kind());
  endtask

  initial begin
    cfg_t c;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (OPENING[i]) send_byte(OPENING[i]);
    run_frames(125);
    wait_idle();
    run_frames(125);

    calm = 1'b1;
    apply_setting(EXTREME_CFG, 1'b1);
    run_frames(200);
    calm = 1'b0;

    apply_setting(DEGENERATE_CFG, 1'b0);
    run_frames(150);

    repeat (2) begin
      c = 56'({$urandom(), $urandom()});
      apply_setting(c, 1'b0);
      run_frames(150);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d received bytes under %0d register settings, with random stalls on both sides.",
             items_sent, settings_used);
    $display("Compared %0d events, %0d of them frame verdicts.", checked, verdicts);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_step.sv
rtl/sfr_skid.sv
rtl/stuffed_frame_receiver_unit.sv
rtl/sfr_checker.sv
test/stuffed_frame_receiver_unit_checker.sv
test/stuffed_frame_receiver_unit_test.sv
